// File: sv/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

    // command characters
    localparam logic [7:0] CMD_OPERATE = 8'h6F;  // 'o'
    localparam logic [7:0] CMD_PREOP   = 8'h70;  // 'p'
    localparam logic [7:0] CMD_RESET   = 8'h72;  // 'r'
    localparam logic [7:0] CMD_MODE_P  = 8'h63;  // 'c'
    localparam logic [7:0] CMD_MODE_PI = 8'h76;  // 'v'

    // controller mode codes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_P    = 2'd1;
    localparam logic [1:0] MODE_PI   = 2'd2;

    // register map
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_PREOP_BLINK   = 2'd0;
    localparam logic [1:0] REG_STOPPED_BLINK = 2'd1;
    localparam logic [1:0] REG_FAULT_HOLD    = 2'd2;

    // register reset values
    localparam logic [15:0] PREOP_BLINK_RST   = 16'd500;
    localparam logic [15:0] STOPPED_BLINK_RST = 16'd250;
    localparam logic [7:0]  FAULT_HOLD_RST    = 8'd5;

    typedef struct packed {
        logic [15:0] preop_blink_ticks;
        logic [15:0] stopped_blink_ticks;
        logic [7:0]  fault_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic       cmd_valid;
        logic [7:0] cmd_byte;
        logic       fault_active;
        logic       update_due;
    } t_item;

    typedef struct packed {
        logic [1:0] drive_state;
        logic       led_level;
        logic       driver_awake;
        logic       run_control;
        logic [1:0] controller_mode;
        logic       fault_seen;
    } t_result;

endpackage

// File: sv/drive_supervisor_state_machine_core.sv
`timescale 1ns / 1ps
// path: a request accepted into the input register moves on to the result
// register once the output is free; an output stall keeps it waiting there
// throughput: one request per cycle unless the output stalls; the input and
// result registers form a two-stage pipeline that holds under output stall
// reset: i_rst_n synchronous, active low; empties the pipeline, puts the
// supervisor in init and loads the register reset values

module drive_supervisor_state_machine_core
    import dss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_cmd_valid,
    input  logic [7:0]        i_cmd_byte,
    input  logic              i_fault_active,
    input  logic              i_update_due,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_drive_state,
    output logic              o_led_level,
    output logic              o_driver_awake,
    output logic              o_run_control,
    output logic [1:0]        o_controller_mode,
    output logic              o_fault_seen,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_item   r_item;
    t_result result;
    logic    r_item_valid;
    logic    r_out_valid;
    logic    out_free;
    logic    in_take;
    logic    step;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_item_valid && out_free;
    assign o_in_stall = r_item_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_take) begin
            r_item_valid <= 1'b1;
        end else if (step) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.cmd_valid    <= i_cmd_valid;
            r_item.cmd_byte     <= i_cmd_byte;
            r_item.fault_active <= i_fault_active;
            r_item.update_due   <= i_update_due;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    dss_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dss_supervisor u_sup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_out_valid       = r_out_valid;
    assign o_drive_state     = result.drive_state;
    assign o_led_level       = result.led_level;
    assign o_driver_awake    = result.driver_awake;
    assign o_run_control     = result.run_control;
    assign o_controller_mode = result.controller_mode;
    assign o_fault_seen      = result.fault_seen;

endmodule

// File: sv/dss_apb_regs.sv
`timescale 1ns / 1ps

module dss_apb_regs
    import dss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [1:0] reg_idx;
    logic       wr_en;
    t_cfg       r_cfg;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes, unmapped addresses ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preop_blink_ticks   <= PREOP_BLINK_RST;
            r_cfg.stopped_blink_ticks <= STOPPED_BLINK_RST;
            r_cfg.fault_hold_ticks    <= FAULT_HOLD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PREOP_BLINK:   r_cfg.preop_blink_ticks   <= pwdata[15:0];
                REG_STOPPED_BLINK: r_cfg.stopped_blink_ticks <= pwdata[15:0];
                REG_FAULT_HOLD:    r_cfg.fault_hold_ticks    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_PREOP_BLINK:   prdata = {16'd0, r_cfg.preop_blink_ticks};
            REG_STOPPED_BLINK: prdata = {16'd0, r_cfg.stopped_blink_ticks};
            REG_FAULT_HOLD:    prdata = {24'd0, r_cfg.fault_hold_ticks};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// File: sv/dss_supervisor.sv
`timescale 1ns / 1ps

module dss_supervisor
    import dss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    typedef enum logic [1:0] {
        ST_INIT  = 2'd0,
        ST_PREOP = 2'd1,
        ST_OPER  = 2'd2,
        ST_STOP  = 2'd3
    } t_state;

    t_state      r_state,  n_state;
    logic [7:0]  r_cmd,    n_cmd;
    logic [15:0] r_blink,  n_blink;
    logic [7:0]  r_age,    n_age;
    logic        r_led,    n_led;
    logic        r_pend,   n_pend;
    logic [1:0]  r_mode,   n_mode;
    t_result     r_result, n_result;

    assign o_result = r_result;

    // one tick of the supervisor
    always_comb begin
        logic        fault;
        logic        awake;
        logic        run;
        logic        tr_valid;
        t_state      tr_state;
        logic [15:0] rate;

        fault    = 1'b0;
        awake    = 1'b0;
        run      = 1'b0;
        tr_valid = 1'b0;
        tr_state = ST_INIT;
        rate     = i_cfg.preop_blink_ticks;

        n_state = r_state;
        n_led   = r_led;
        n_mode  = r_mode;

        // latch the new command
        n_cmd = i_item.cmd_valid ? i_item.cmd_byte : r_cmd;

        // fault age, saturating
        if (i_item.fault_active) begin
            n_age = (r_age == 8'hFF) ? r_age : r_age + 8'd1;
            fault = (n_age > i_cfg.fault_hold_ticks);
        end else begin
            n_age = 8'd0;
        end

        n_pend  = r_pend | i_item.update_due;
        n_blink = (r_blink == 16'hFFFF) ? r_blink : r_blink + 16'd1;

        // transition decode from the latched command
        if (n_cmd == CMD_OPERATE) begin
            tr_valid = 1'b1;
            tr_state = ST_OPER;
        end else if (n_cmd == CMD_PREOP) begin
            tr_valid = 1'b1;
            tr_state = ST_PREOP;
        end else if (n_cmd == CMD_RESET) begin
            tr_valid = 1'b1;
            tr_state = ST_INIT;
        end

        if (r_state == ST_STOP) begin
            rate = i_cfg.stopped_blink_ticks;
        end

        unique case (r_state)
            ST_INIT: begin
                n_cmd   = 8'd0;
                n_led   = 1'b0;
                n_state = ST_PREOP;
            end
            ST_PREOP: begin
                if (n_blink > rate) begin
                    n_led   = ~r_led;
                    n_blink = 16'd0;
                end
                if (n_cmd == CMD_MODE_P) begin
                    n_mode = MODE_P;
                    n_cmd  = 8'd0;
                end else if (n_cmd == CMD_MODE_PI) begin
                    n_mode = MODE_PI;
                    n_cmd  = 8'd0;
                end
                if (fault) begin
                    n_state = ST_STOP;
                end else if (tr_valid && tr_state != ST_PREOP) begin
                    n_state = tr_state;
                    n_cmd   = 8'd0;
                end
            end
            ST_OPER: begin
                n_led = 1'b1;
                awake = 1'b1;
                if (n_pend) begin
                    run    = (r_mode != MODE_NONE);
                    n_pend = 1'b0;
                end
                if (fault) begin
                    n_state = ST_STOP;
                end else if (tr_valid && tr_state != ST_OPER) begin
                    n_state = tr_state;
                    n_cmd   = 8'd0;
                end
            end
            ST_STOP: begin
                if (n_blink > rate) begin
                    n_led   = ~r_led;
                    n_blink = 16'd0;
                end
                if (tr_valid) begin
                    n_state = tr_state;
                    n_cmd   = 8'd0;
                end
            end
            default: ;
        endcase

        n_result.drive_state     = n_state;
        n_result.led_level       = n_led;
        n_result.driver_awake    = awake;
        n_result.run_control     = run;
        n_result.controller_mode = n_mode;
        n_result.fault_seen      = fault;
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cmd   <= 8'd0;
            r_blink <= 16'd0;
            r_age   <= 8'd0;
            r_led   <= 1'b0;
            r_pend  <= 1'b0;
            r_mode  <= MODE_NONE;
        end else if (i_step) begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_blink <= n_blink;
            r_age   <= n_age;
            r_led   <= n_led;
            r_pend  <= n_pend;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result <= n_result;
        end
    end

endmodule

// File: sv/dss_checker.sv
`timescale 1ns / 1ps

module dss_checker
    import dss_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_drive_state,
    input logic       o_led_level,
    input logic       o_driver_awake,
    input logic       o_run_control,
    input logic [1:0] o_controller_mode,
    input logic       o_fault_seen
);

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an operational tick always leaves the led on
    a_awake_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_driver_awake |-> o_led_level)
        else $error("driver awake with led off");

    // a control update needs the operational state and a chosen mode
    a_run_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_control |->
            o_driver_awake && o_controller_mode != MODE_NONE)
        else $error("control update without operational state or mode");

    // mode only ever moves away from none, never back
    a_mode_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_controller_mode != MODE_NONE && !i_out_stall
            ##1 o_out_valid |-> o_controller_mode != MODE_NONE)
        else $error("controller mode returned to none");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive_state)
            && $stable(o_led_level) && $stable(o_run_control)
            && $stable(o_fault_seen))
        else $error("stalled result changed");

endmodule

bind drive_supervisor_state_machine_core dss_checker u_dss_checker (.*);
